// File: design/lrle_pkg.sv
// shared types, character codes and constants of the rle pattern decoder
package lrle_pkg;

	localparam int DEFAULT_MAX_SIDE = 256;
	localparam int QUEUE_DEPTH      = 4;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 9;

	localparam logic [CFG_INDEX_W-1:0] REG_BOARD_WIDTH  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_BOARD_HEIGHT = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_ROW   = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_COL   = 2'd3;

	localparam logic [8:0] RST_BOARD_WIDTH  = 9'd30;
	localparam logic [8:0] RST_BOARD_HEIGHT = 9'd30;
	localparam logic [7:0] RST_ORIGIN_ROW   = 8'd2;
	localparam logic [7:0] RST_ORIGIN_COL   = 8'd5;

	localparam logic [7:0] CHAR_ZERO   = 8'h30;
	localparam logic [7:0] CHAR_NINE   = 8'h39;
	localparam logic [7:0] CHAR_DEAD   = 8'h62;
	localparam logic [7:0] CHAR_ALIVE  = 8'h6F;
	localparam logic [7:0] CHAR_NEWROW = 8'h24;
	localparam logic [7:0] CHAR_END    = 8'h21;

	localparam logic [15:0] COUNT_MAX = 16'hFFFF;
	localparam logic [16:0] INDEX_MAX = 17'h1FFFF;
	localparam logic [15:0] START_MAX = 16'hFFFF;

	typedef enum logic [2:0] {
		CMD_NONE,
		CMD_DIGIT,
		CMD_RUN,
		CMD_LINE,
		CMD_END
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t  kind;
		logic [3:0] digit;
		logic       alive;
		logic       first;
	} cmd_t;

	typedef struct packed {
		logic [8:0] board_width;
		logic [8:0] board_height;
		logic [7:0] origin_row;
		logic [7:0] origin_col;
	} cfg_t;

	typedef struct packed {
		logic [15:0] run_start;
		logic [15:0] run_length;
		logic        cell_alive;
		logic        run_past_end;
		logic        pattern_done;
	} result_t;

endpackage

// File: design/life_rle_pattern_decoder.sv
// top level of the run-length pattern decoder: ports, registers, front, queue, back
//
// channel   dir  handshake            payload
// s_*       in   s_tvalid / s_tready  s_tdata[7:0] char_code, s_tuser first_char
// m_*       out  m_tvalid / m_tready  m_tdata run_start, run_length, cell_alive;
//                                     m_tuser run_past_end, m_tlast pattern_done
// cfg_*     in   cfg_valid / cfg_ready cfg_index register, cfg_data value
//
// one character per cycle unless the queue is full; back end: one command a cycle, unless stalled
// its longest path is one multiply (origin row times width on a restart) followed
// by two add-and-saturate steps; count times width runs beside it
// a run or end character is written into the queue, taken from it by the back end once
// the output register is free, and its result is registered into the output register on m_*
// the four-deep command queue lets the input run on while m_tready is low;
// s_tready drops only when the queue is full
// arst_n clears position, count and handshake state and loads register defaults
module life_rle_pattern_decoder #(
	parameter int MAX_SIDE = lrle_pkg::DEFAULT_MAX_SIDE
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [7:0]                      s_tdata,   // char_code
	input  logic                            s_tuser,   // first_char
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [39:0]                     m_tdata,   // run_start, run_length, cell_alive, zero fill
	output logic                            m_tuser,   // run_past_end
	output logic                            m_tlast,   // pattern_done
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [lrle_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [lrle_pkg::CFG_DATA_W-1:0]  cfg_data
);

	lrle_pkg::cfg_t    cfg_q;
	lrle_pkg::cmd_t    front_cmd;
	lrle_pkg::cmd_t    queue_cmd;
	lrle_pkg::result_t res;
	logic              front_valid;
	logic              front_ready;
	logic              queue_valid;
	logic              queue_ready;

	// registers are always writable
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.board_width  <= lrle_pkg::RST_BOARD_WIDTH;
			cfg_q.board_height <= lrle_pkg::RST_BOARD_HEIGHT;
			cfg_q.origin_row   <= lrle_pkg::RST_ORIGIN_ROW;
			cfg_q.origin_col   <= lrle_pkg::RST_ORIGIN_COL;
		end else if (cfg_valid) begin
			case (cfg_index)
				lrle_pkg::REG_BOARD_WIDTH:  cfg_q.board_width  <= cfg_data;
				lrle_pkg::REG_BOARD_HEIGHT: cfg_q.board_height <= cfg_data;
				lrle_pkg::REG_ORIGIN_ROW:   cfg_q.origin_row   <= cfg_data[7:0];
				lrle_pkg::REG_ORIGIN_COL:   cfg_q.origin_col   <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	// classify characters; ignored ones are consumed without a queue entry
	lrle_front u_front (
		.char_valid (s_tvalid),
		.char_ready (s_tready),
		.char_code  (s_tdata),
		.first_char (s_tuser),
		.cmd_valid  (front_valid),
		.cmd_ready  (front_ready),
		.cmd        (front_cmd)
	);

	lrle_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.push_data  (front_cmd),
		.pop_valid  (queue_valid),
		.pop_ready  (queue_ready),
		.pop_data   (queue_cmd)
	);

	// position tracking, run emission and the output register
	lrle_back #(
		.MAX_SIDE (MAX_SIDE)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd_valid (queue_valid),
		.cmd_ready (queue_ready),
		.cmd       (queue_cmd),
		.res_valid (m_tvalid),
		.res_ready (m_tready),
		.res       (res)
	);

	assign m_tdata = {7'd0, res.cell_alive, res.run_length, res.run_start};
	assign m_tuser = res.run_past_end;
	assign m_tlast = res.pattern_done;

endmodule

// File: design/lrle_front.sv
// front end: classifies each character into a decoder command
module lrle_front (
	input  logic          char_valid,
	output logic          char_ready,
	input  logic [7:0]    char_code,
	input  logic          first_char,
	output logic          cmd_valid,
	input  logic          cmd_ready,
	output lrle_pkg::cmd_t cmd
);

	lrle_pkg::cmd_kind_t kind;

	always_comb begin
		if (char_code >= lrle_pkg::CHAR_ZERO && char_code <= lrle_pkg::CHAR_NINE) begin
			kind = lrle_pkg::CMD_DIGIT;
		end else if (char_code == lrle_pkg::CHAR_DEAD || char_code == lrle_pkg::CHAR_ALIVE) begin
			kind = lrle_pkg::CMD_RUN;
		end else if (char_code == lrle_pkg::CHAR_NEWROW) begin
			kind = lrle_pkg::CMD_LINE;
		end else if (char_code == lrle_pkg::CHAR_END) begin
			kind = lrle_pkg::CMD_END;
		end else begin
			kind = lrle_pkg::CMD_NONE;
		end
	end

	assign cmd.kind  = kind;
	assign cmd.digit = 4'(char_code - lrle_pkg::CHAR_ZERO);
	assign cmd.alive = (char_code == lrle_pkg::CHAR_ALIVE);
	assign cmd.first = first_char;

	// unknown characters without a restart change nothing: drop them here
	assign char_ready = cmd_ready;
	assign cmd_valid  = char_valid && (kind != lrle_pkg::CMD_NONE || first_char);

endmodule

// File: design/lrle_queue.sv
// short command queue between the front and back ends
module lrle_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  lrle_pkg::cmd_t push_data,
	output logic           pop_valid,
	input  logic           pop_ready,
	output lrle_pkg::cmd_t pop_data
);

	localparam int PW = $clog2(lrle_pkg::QUEUE_DEPTH);

	lrle_pkg::cmd_t mem_q [lrle_pkg::QUEUE_DEPTH];
	logic [PW:0]    wr_ptr_q;
	logic [PW:0]    rd_ptr_q;
	logic           full;
	logic           empty;

	assign empty = (wr_ptr_q == rd_ptr_q);
	assign full  = (wr_ptr_q[PW-1:0] == rd_ptr_q[PW-1:0]) && (wr_ptr_q[PW] != rd_ptr_q[PW]);

	assign push_ready = !full;
	assign pop_valid  = !empty;
	assign pop_data   = mem_q[rd_ptr_q[PW-1:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			if (push_valid && !full) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop_ready && !empty) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push_valid && !full) begin
			mem_q[wr_ptr_q[PW-1:0]] <= push_data;
		end
	end

endmodule

// File: design/lrle_back.sv
// back end: count, position state and the result register
module lrle_back #(
	parameter int MAX_SIDE = lrle_pkg::DEFAULT_MAX_SIDE
) (
	input  logic              clk,
	input  logic              arst_n,
	input  lrle_pkg::cfg_t    cfg,
	input  logic              cmd_valid,
	output logic              cmd_ready,
	input  lrle_pkg::cmd_t    cmd,
	output logic              res_valid,
	input  logic              res_ready,
	output lrle_pkg::result_t res
);

	localparam int SW = $clog2(MAX_SIDE + 1);
	localparam int CW = (SW > 9) ? SW : 9;
	localparam int OW = (SW + 9 > 18) ? SW + 9 : 18;
	localparam int LW = SW + 17;
	localparam int XW = (2 * SW > 18) ? 2 * SW : 18;

	function automatic logic [SW-1:0] clamp_side(input logic [8:0] v);
		logic [SW-1:0] r;
		if (v == 9'd0) begin
			r = SW'(1);
		end else if (CW'(v) > CW'(MAX_SIDE)) begin
			r = SW'(MAX_SIDE);
		end else begin
			r = SW'(v);
		end
		return r;
	endfunction

	logic [15:0] run_count_q;
	logic        count_present_q;
	logic [16:0] line_start_q;
	logic [16:0] write_index_q;
	logic        finished_q;
	logic        res_valid_q;
	lrle_pkg::result_t res_q;

	logic [SW-1:0]   w;
	logic [SW-1:0]   h;
	logic [2*SW-1:0] total;
	logic [OW-1:0]   origin_sum;
	logic [16:0]     origin_idx;

	logic [15:0] rc_eff;
	logic        cp_eff;
	logic [16:0] ls_eff;
	logic [16:0] wi_eff;
	logic        fin_eff;
	logic [15:0] count;

	logic [19:0]   digit_next;
	logic [17:0]   run_end;
	logic [LW-1:0] line_sum;
	logic [16:0]   line_next;
	logic [15:0]   start_sat;
	logic          past;

	logic              take;
	logic [15:0]       rc_n;
	logic              cp_n;
	logic [16:0]       ls_n;
	logic [16:0]       wi_n;
	logic              fin_n;
	logic              emit;
	lrle_pkg::result_t res_n;

	assign w = clamp_side(cfg.board_width);
	assign h = clamp_side(cfg.board_height);
	assign total = w * h;

	assign origin_sum = OW'(cfg.origin_row) * OW'(w) + OW'(cfg.origin_col);
	assign origin_idx = (origin_sum > OW'(lrle_pkg::INDEX_MAX)) ?
		lrle_pkg::INDEX_MAX : origin_sum[16:0];

	// a restart clears the count and puts the position at the origin first
	assign rc_eff  = cmd.first ? 16'd0 : run_count_q;
	assign cp_eff  = cmd.first ? 1'b0 : count_present_q;
	assign ls_eff  = cmd.first ? origin_idx : line_start_q;
	assign wi_eff  = cmd.first ? origin_idx : write_index_q;
	assign fin_eff = cmd.first ? 1'b0 : finished_q;
	assign count   = cp_eff ? rc_eff : 16'd1;

	assign digit_next = 20'(rc_eff) * 20'd10 + 20'(cmd.digit);
	assign run_end    = 18'(wi_eff) + 18'(count);
	assign line_sum   = LW'(ls_eff) + LW'(count) * LW'(w);
	assign line_next  = (line_sum > LW'(lrle_pkg::INDEX_MAX)) ?
		lrle_pkg::INDEX_MAX : line_sum[16:0];
	assign start_sat  = (wi_eff > 17'(lrle_pkg::START_MAX)) ?
		lrle_pkg::START_MAX : wi_eff[15:0];
	assign past = (XW'(run_end) > XW'(total)) || (wi_eff > 17'(lrle_pkg::START_MAX));

	assign cmd_ready = !res_valid_q || res_ready;
	assign take      = cmd_valid && cmd_ready;

	always_comb begin
		rc_n  = rc_eff;
		cp_n  = cp_eff;
		ls_n  = ls_eff;
		wi_n  = wi_eff;
		fin_n = fin_eff;
		emit  = 1'b0;
		res_n = '0;
		if (!fin_eff) begin
			case (cmd.kind)
				lrle_pkg::CMD_DIGIT: begin
					rc_n = (digit_next > 20'(lrle_pkg::COUNT_MAX)) ?
						lrle_pkg::COUNT_MAX : digit_next[15:0];
					cp_n = 1'b1;
				end
				lrle_pkg::CMD_RUN: begin
					emit               = 1'b1;
					res_n.run_start    = start_sat;
					res_n.run_length   = count;
					res_n.cell_alive   = cmd.alive;
					res_n.run_past_end = past;
					wi_n = (run_end > 18'(lrle_pkg::INDEX_MAX)) ?
						lrle_pkg::INDEX_MAX : run_end[16:0];
					rc_n = 16'd0;
					cp_n = 1'b0;
				end
				lrle_pkg::CMD_LINE: begin
					ls_n = line_next;
					wi_n = line_next;
					rc_n = 16'd0;
					cp_n = 1'b0;
				end
				lrle_pkg::CMD_END: begin
					emit               = 1'b1;
					res_n.run_start    = start_sat;
					res_n.pattern_done = 1'b1;
					fin_n = 1'b1;
					rc_n  = 16'd0;
					cp_n  = 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_count_q     <= '0;
			count_present_q <= 1'b0;
			line_start_q    <= '0;
			write_index_q   <= '0;
			finished_q      <= 1'b0;
			res_valid_q     <= 1'b0;
		end else begin
			if (take) begin
				run_count_q     <= rc_n;
				count_present_q <= cp_n;
				line_start_q    <= ls_n;
				write_index_q   <= wi_n;
				finished_q      <= fin_n;
			end
			if (take && emit) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && emit) begin
			res_q <= res_n;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule
